// ===== design/i2c_master_bit_engine_macros.svh =====
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

`define I2CMBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define I2CMBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

  localparam int unsigned WAIT_BITS   = 16;
  localparam int unsigned HALF_RESET  = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_PROBE = 3'd5;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ,
    CMD_PROBE
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== design/i2c_master_bit_engine.sv =====
// I2C master bit engine. Every input item is one timing tick: it carries the sampled
// SDA level and an optional command (start, stop, write byte, read byte, address
// probe), and yields exactly one result item with the SCL/SDA drive, busy and done
// flags, the last read byte and the last write acknowledge. Commands arriving while
// busy are dropped. Throughput is one item per clock cycle unless out_ready_i holds
// it off; items go through the two-entry queue between the decode front and the
// sequencer back, then the result register. The input side stalls only when the
// output side holds off ready long enough to fill the queue. The user must write
// half_period_ticks via cfg_we_i/cfg_wdata_i only while no item is in flight; the
// block does not enforce it. Its low WaitBits bits set the ticks between bus edges.
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine #(
  parameter int unsigned WaitBits = i2cmbe_pkg::WAIT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        send_ack_i,
  input  logic        sda_sampled_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_level_o,
  output logic        sda_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_seen_o
);

  i2cmbe_pkg::queue_status_t q_status;
  i2cmbe_pkg::item_t         push_item, head_item;
  logic                      push, pop;

  i2cmbe_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .tx_byte_i     (tx_byte_i),
    .send_ack_i    (send_ack_i),
    .sda_sampled_i (sda_sampled_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .item_o        (push_item)
  );

  i2cmbe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  i2cmbe_back #(
    .WaitBits (WaitBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (head_item),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_level_o (scl_level_o),
    .sda_level_o (sda_level_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .ack_seen_o  (ack_seen_o)
  );

  `I2CMBE_ASSERT_IMP(a_done_not_busy, out_valid_o && done_res_o, !busy_res_o)
  `I2CMBE_ASSERT_IMP(a_done_bus_safe, out_valid_o && done_res_o, !scl_level_o || sda_level_o)
  `I2CMBE_ASSERT_IMP(a_full_only_stalled, !in_ready_o, out_valid_o)
  `I2CMBE_ASSERT_NXT(a_item_kept, in_valid_i && in_ready_o, out_valid_o || !q_status.empty)

endmodule

// ===== design/i2cmbe_front.sv =====
module i2cmbe_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                opcode_i,
  input  logic [7:0]                tx_byte_i,
  input  logic                      send_ack_i,
  input  logic                      sda_sampled_i,
  input  i2cmbe_pkg::queue_status_t q_status_i,
  output logic                      push_o,
  output i2cmbe_pkg::item_t         item_o
);

  i2cmbe_pkg::cmd_e cmd;

  always_comb begin
    unique case (opcode_i)
      i2cmbe_pkg::OP_START: cmd = i2cmbe_pkg::CMD_START;
      i2cmbe_pkg::OP_STOP:  cmd = i2cmbe_pkg::CMD_STOP;
      i2cmbe_pkg::OP_WRITE: cmd = i2cmbe_pkg::CMD_WRITE;
      i2cmbe_pkg::OP_READ:  cmd = i2cmbe_pkg::CMD_READ;
      i2cmbe_pkg::OP_PROBE: cmd = i2cmbe_pkg::CMD_PROBE;
      default:              cmd = i2cmbe_pkg::CMD_NONE;
    endcase
  end

  assign in_ready_o       = !q_status_i.full;
  assign push_o           = in_valid_i && !q_status_i.full;
  assign item_o.cmd       = cmd;
  assign item_o.tx_byte   = tx_byte_i;
  assign item_o.send_ack  = send_ack_i;
  assign item_o.sda       = sda_sampled_i;

endmodule

// ===== design/i2cmbe_queue.sv =====
module i2cmbe_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  i2cmbe_pkg::item_t         item_i,
  input  logic                      pop_i,
  output i2cmbe_pkg::item_t         item_o,
  output i2cmbe_pkg::queue_status_t status_o
);

  localparam int unsigned Depth = i2cmbe_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = i2cmbe_pkg::QUEUE_PW;

  i2cmbe_pkg::item_t entry_q [Depth];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]       cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == (PW+1)'(Depth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = entry_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== design/i2cmbe_back.sv =====
module i2cmbe_back #(
  parameter int unsigned WaitBits = i2cmbe_pkg::WAIT_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [15:0]               cfg_wdata_i,
  input  i2cmbe_pkg::item_t         item_i,
  input  i2cmbe_pkg::queue_status_t q_status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      scl_level_o,
  output logic                      sda_level_o,
  output logic                      busy_res_o,
  output logic                      done_res_o,
  output logic [7:0]                rx_byte_o,
  output logic                      ack_seen_o
);

  localparam logic [2:0] PH_0 = 3'd0;
  localparam logic [2:0] PH_1 = 3'd1;
  localparam logic [2:0] PH_2 = 3'd2;
  localparam logic [2:0] PH_3 = 3'd3;
  localparam logic [2:0] PH_4 = 3'd4;

  logic [15:0]         half_q;
  logic [WaitBits+15:0] half_ext;
  logic [WaitBits-1:0] load_val;
  logic [2:0]          mode_q, mode_d;
  logic [2:0]          phase_q, phase_d;
  logic [3:0]          bits_q, bits_d;
  logic [WaitBits-1:0] wait_q, wait_d;
  logic [7:0]          shift_q, shift_d;
  logic                ack_q, ack_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                ack_tx_q, ack_tx_d;
  logic [1:0]          probe_q, probe_d;
  logic [7:0]          rx_q, rx_d;
  logic                done;
  logic                fin;
  logic                step;
  logic                out_valid_q;

  assign half_ext = {{WaitBits{1'b0}}, half_q};
  assign load_val = half_ext[WaitBits-1:0];
  assign step     = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign pop_o    = step;

  always_comb begin
    mode_d   = mode_q;
    phase_d  = phase_q;
    bits_d   = bits_q;
    wait_d   = wait_q;
    shift_d  = shift_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_tx_d = ack_tx_q;
    probe_d  = probe_q;
    rx_d     = rx_q;
    done     = 1'b0;
    fin      = 1'b0;
    if (mode_q == i2cmbe_pkg::MODE_IDLE) begin
      case (item_i.cmd) inside
        i2cmbe_pkg::CMD_START, i2cmbe_pkg::CMD_PROBE: begin
          mode_d  = i2cmbe_pkg::MODE_START;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          wait_d  = load_val;
          phase_d = PH_1;
          if (item_i.cmd == i2cmbe_pkg::CMD_PROBE) begin
            probe_d = 2'd1;
            shift_d = {item_i.tx_byte[6:0], 1'b0};
          end
        end
        i2cmbe_pkg::CMD_STOP: begin
          mode_d  = i2cmbe_pkg::MODE_STOP;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          wait_d  = load_val;
          phase_d = PH_1;
        end
        i2cmbe_pkg::CMD_WRITE: begin
          mode_d  = i2cmbe_pkg::MODE_WRITE;
          shift_d = item_i.tx_byte;
          bits_d  = 4'd8;
          sda_d   = item_i.tx_byte[7];
          wait_d  = load_val;
          phase_d = PH_1;
        end
        i2cmbe_pkg::CMD_READ: begin
          mode_d   = i2cmbe_pkg::MODE_READ;
          shift_d  = 8'h00;
          bits_d   = 4'd8;
          ack_tx_d = item_i.send_ack;
          scl_d    = 1'b0;
          sda_d    = 1'b1;
          wait_d   = load_val;
          phase_d  = PH_1;
        end
        default: ;
      endcase
    end else if (wait_q > WaitBits'(1)) begin
      wait_d = wait_q - WaitBits'(1);
    end else begin
      unique case (mode_q)
        i2cmbe_pkg::MODE_START: begin
          if (phase_q == PH_1) begin
            sda_d = 1'b0; wait_d = load_val; phase_d = PH_2;
          end else begin
            scl_d = 1'b0; fin = 1'b1;
          end
        end
        i2cmbe_pkg::MODE_STOP: begin
          if (phase_q == PH_1) begin
            scl_d = 1'b1; wait_d = load_val; phase_d = PH_2;
          end else if (phase_q == PH_2) begin
            sda_d = 1'b1; wait_d = load_val; phase_d = PH_3;
          end else begin
            fin = 1'b1;
          end
        end
        i2cmbe_pkg::MODE_WRITE: begin
          if (phase_q == PH_1) begin
            scl_d = 1'b1; wait_d = load_val; phase_d = PH_2;
          end else if (phase_q == PH_2) begin
            scl_d   = 1'b0;
            bits_d  = bits_q - 4'd1;
            shift_d = {shift_q[6:0], 1'b0};
            if (bits_d != 4'd0) begin
              sda_d   = shift_q[6];
              phase_d = PH_1;
            end else begin
              sda_d   = 1'b1;
              phase_d = PH_3;
            end
            wait_d = load_val;
          end else if (phase_q == PH_3) begin
            scl_d   = 1'b1;
            ack_d   = !item_i.sda;
            wait_d  = load_val;
            phase_d = PH_4;
          end else begin
            scl_d = 1'b0; fin = 1'b1;
          end
        end
        i2cmbe_pkg::MODE_READ: begin
          if (phase_q == PH_0) begin
            scl_d = 1'b0; wait_d = load_val; phase_d = PH_1;
          end else if (phase_q == PH_1) begin
            scl_d   = 1'b1;
            shift_d = {shift_q[6:0], item_i.sda};
            bits_d  = bits_q - 4'd1;
            wait_d  = load_val;
            phase_d = (bits_d != 4'd0) ? PH_0 : PH_2;
          end else if (phase_q == PH_2) begin
            scl_d   = 1'b0;
            sda_d   = !ack_tx_q;
            wait_d  = load_val;
            phase_d = PH_3;
          end else if (phase_q == PH_3) begin
            scl_d = 1'b1; wait_d = load_val; phase_d = PH_4;
          end else begin
            scl_d = 1'b0;
            rx_d  = shift_q;
            fin   = 1'b1;
          end
        end
        default: mode_d = i2cmbe_pkg::MODE_IDLE;
      endcase
    end
    if (fin) begin
      if (probe_q == 2'd1) begin
        probe_d = 2'd2;
        mode_d  = i2cmbe_pkg::MODE_WRITE;
        bits_d  = 4'd8;
        sda_d   = shift_q[7];
        wait_d  = load_val;
        phase_d = PH_1;
      end else if (probe_q == 2'd2) begin
        probe_d = 2'd3;
        mode_d  = i2cmbe_pkg::MODE_STOP;
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        wait_d  = load_val;
        phase_d = PH_1;
      end else begin
        probe_d = 2'd0;
        mode_d  = i2cmbe_pkg::MODE_IDLE;
        phase_d = PH_0;
        wait_d  = '0;
        done    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 16'(i2cmbe_pkg::HALF_RESET);
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= i2cmbe_pkg::MODE_IDLE;
      phase_q  <= PH_0;
      bits_q   <= '0;
      wait_q   <= '0;
      shift_q  <= '0;
      ack_q    <= 1'b0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_tx_q <= 1'b0;
      probe_q  <= '0;
      rx_q     <= '0;
    end else if (step) begin
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      bits_q   <= bits_d;
      wait_q   <= wait_d;
      shift_q  <= shift_d;
      ack_q    <= ack_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_tx_q <= ack_tx_d;
      probe_q  <= probe_d;
      rx_q     <= rx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      scl_level_o <= scl_d;
      sda_level_o <= sda_d;
      busy_res_o  <= (mode_d != i2cmbe_pkg::MODE_IDLE);
      done_res_o  <= done;
      rx_byte_o   <= rx_d;
      ack_seen_o  <= ack_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
